>>> hdl/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types and constants of the circumcircle unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tcc_pkg;

  // stage control handed down the cell rows
  typedef struct packed {
    logic en;
    logic valid;
  } stage_ctl_t;

  localparam int unsigned LIMIT_W = 16;
  localparam logic [LIMIT_W-1:0] DEG_LIMIT_RST = 16'd1;

endpackage

`default_nettype wire

>>> hdl/tcc_div_cell.sv
// ----------------------------------------------------------------------------
// tcc_div_cell
// One restoring division step for the x and y quotients (shared divisor).
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_div_cell #(
  parameter int DW   = 37,
  parameter int QB   = 19,
  parameter int STEP = 0,
  parameter int SW   = 37
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  tcc_pkg::stage_ctl_t   ctl_in,
  input  wire  [DW-1:0]         den_in,
  input  wire  [DW+QB-1:0]      rem_x_in,
  input  wire  [DW+QB-1:0]      rem_y_in,
  input  wire  [QB-1:0]         quo_x_in,
  input  wire  [QB-1:0]         quo_y_in,
  input  wire  [SW-1:0]         side_in,
  output logic                  valid_out,
  output logic [DW-1:0]         den_out,
  output logic [DW+QB-1:0]      rem_x_out,
  output logic [DW+QB-1:0]      rem_y_out,
  output logic [QB-1:0]         quo_x_out,
  output logic [QB-1:0]         quo_y_out,
  output logic [SW-1:0]         side_out
);

  localparam int RW = DW + QB;

  logic [RW-1:0] trial;
  logic          ge_x, ge_y;
  logic [RW-1:0] rem_x_nxt, rem_y_nxt;
  logic [QB-1:0] quo_x_nxt, quo_y_nxt;

  always_comb begin
    trial     = {{QB{1'b0}}, den_in} << STEP;
    ge_x      = rem_x_in >= trial;
    ge_y      = rem_y_in >= trial;
    rem_x_nxt = ge_x ? rem_x_in - trial : rem_x_in;
    rem_y_nxt = ge_y ? rem_y_in - trial : rem_y_in;
    quo_x_nxt = quo_x_in;
    quo_y_nxt = quo_y_in;
    quo_x_nxt[STEP] = ge_x;
    quo_y_nxt[STEP] = ge_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_out <= 1'b0;
    end else if (ctl_in.en) begin
      valid_out <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.en) begin
      den_out   <= den_in;
      rem_x_out <= rem_x_nxt;
      rem_y_out <= rem_y_nxt;
      quo_x_out <= quo_x_nxt;
      quo_y_out <= quo_y_nxt;
      side_out  <= side_in;
    end
  end

endmodule

`default_nettype wire

>>> hdl/tcc_sqrt_cell.sv
// ----------------------------------------------------------------------------
// tcc_sqrt_cell
// One digit step of the bitwise integer square root.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_sqrt_cell #(
  parameter int VW   = 36,
  parameter int STEP = 0,
  parameter int SW   = 35
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  tcc_pkg::stage_ctl_t   ctl_in,
  input  wire  [VW-1:0]         x_in,
  input  wire  [VW-1:0]         r_in,
  input  wire  [SW-1:0]         side_in,
  output logic                  valid_out,
  output logic [VW-1:0]         x_out,
  output logic [VW-1:0]         r_out,
  output logic [SW-1:0]         side_out
);

  localparam logic [VW-1:0] BIT = {{(VW-1){1'b0}}, 1'b1} << (2 * STEP);

  logic [VW-1:0] trial;
  logic          ge;
  logic [VW-1:0] x_nxt, r_nxt;

  always_comb begin
    trial = r_in + BIT;
    ge    = x_in >= trial;
    x_nxt = ge ? x_in - trial : x_in;
    r_nxt = ge ? (r_in >> 1) + BIT : (r_in >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_out <= 1'b0;
    end else if (ctl_in.en) begin
      valid_out <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.en) begin
      x_out    <= x_nxt;
      r_out    <= r_nxt;
      side_out <= side_in;
    end
  end

endmodule

`default_nettype wire

>>> hdl/triangle_circumcircle_unit.sv
// ----------------------------------------------------------------------------
// triangle_circumcircle_unit
// Centre and radius of the circle through three Q8.8 points.
// ----------------------------------------------------------------------------
// Takes one point triple per clock while the pipe is not held and returns one
// result per triple, in order. Six front stages form the denominator and the
// numerators, a row of COORD_BITS+3 division cells yields one quotient bit
// per cell for both centre coordinates, five stages clip and square the
// offsets, and a row of COORD_BITS+2 root cells yields one root bit per cell.
// The whole pipe holds when a result is waiting and the last stage is full.
// The user must write degenerate_limit on the cfg channel only while no
// triple is in flight; the block itself does not enforce this.
`default_nettype none

module triangle_circumcircle_unit #(
  parameter int COORD_BITS = 16
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // ax, ay, bx, by_coord, cx, cy
  input  wire  [((6*COORD_BITS+7)/8)*8-1:0]   in_tdata,
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  // centre_x, centre_y, radius
  output logic [((3*COORD_BITS+7)/8)*8-1:0]   out_tdata,
  // degenerate, saturated
  output logic [1:0]                          out_tuser,
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  input  wire  [tcc_pkg::LIMIT_W-1:0]         cfg_data,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready
);

  import tcc_pkg::*;

  localparam int W    = COORD_BITS;
  localparam int DIFW = W + 1;
  localparam int SQW  = 2 * W;
  localparam int PW   = 2 * W + 2;
  localparam int SSW  = 2 * W + 2;
  localparam int DENW = 2 * W + 4;
  localparam int NPW  = 3 * W + 3;
  localparam int NW   = 3 * W + 4;
  localparam int DW   = DENW + 1;
  localparam int QB   = W + 3;
  localparam int RW   = DW + QB;
  localparam int QSW  = QB + 1;
  localparam int EW   = QB + 2;
  localparam int UW   = W + 1;
  localparam int SK   = W + 2;
  localparam int VW   = 2 * SK;
  localparam int RTW  = SK + 1;
  localparam int DSW  = 2 * W + 5;
  localparam int SSD  = 2 * W + 3;
  localparam int OUTW = ((3 * W + 7) / 8) * 8;

  localparam logic signed [QSW-1:0] C_HI = (QSW'(1) <<< (W - 1)) - QSW'(1);
  localparam logic signed [QSW-1:0] C_LO = -(QSW'(1) <<< (W - 1));
  localparam logic [EW-1:0]         LIM  = EW'(1) << (W + 1);
  localparam logic [RTW-1:0]        RMAX = (RTW'(1) << W) - RTW'(1);

  logic adv, out_load;
  logic [LIMIT_W-1:0] limit_r;

  // config
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= DEG_LIMIT_RST;
    end else if (cfg_valid) begin
      limit_r <= cfg_data;
    end
  end

  logic signed [W-1:0] in_ax, in_ay, in_bx, in_by, in_cx, in_cy;
  assign in_ax = in_tdata[0*W +: W];
  assign in_ay = in_tdata[1*W +: W];
  assign in_bx = in_tdata[2*W +: W];
  assign in_by = in_tdata[3*W +: W];
  assign in_cx = in_tdata[4*W +: W];
  assign in_cy = in_tdata[5*W +: W];

  // stage 1: differences and squares
  logic                   v1_r;
  logic signed [W-1:0]    ax1_r, ay1_r;
  logic signed [DIFW-1:0] dx1_r, dy1_r, dx2_r, dy2_r;
  logic signed [SQW-1:0]  ax2_r, ay2_r, bx2_r, by2_r, cx2_r, cy2_r;
  // stage 2
  logic                   v2_r;
  logic signed [W-1:0]    ax2c_r, ay2c_r;
  logic signed [DIFW-1:0] dx1b_r, dy1b_r, dx2b_r, dy2b_r;
  logic signed [PW-1:0]   p1_r, p2_r;
  logic signed [SSW-1:0]  s1_r, s2_r;
  // stage 3
  logic                   v3_r;
  logic signed [W-1:0]    ax3_r, ay3_r;
  logic signed [DENW-1:0] den3_r;
  logic signed [NPW-1:0]  m1_r, m2_r, m3_r, m4_r;
  // stage 4
  logic                   v4_r;
  logic signed [W-1:0]    ax4_r, ay4_r;
  logic signed [NW-1:0]   nx_r, ny_r;
  logic [DENW-1:0]        dmag_r;
  logic                   dsgn4_r, degen4_r;
  // stage 5
  logic                   v5_r;
  logic signed [W-1:0]    ax5_r, ay5_r;
  logic [RW-1:0]          nnx5_r, nny5_r;
  logic [DW-1:0]          dd5_r;
  logic                   negx5_r, negy5_r, degen5_r;
  // stage 6
  logic                   v6_r;
  logic signed [W-1:0]    ax6_r, ay6_r;
  logic [RW-1:0]          nnx6_r, nny6_r;
  logic [DW-1:0]          dd6_r;
  logic                   negx6_r, negy6_r, degen6_r, ovx6_r, ovy6_r;

  logic [NW-1:0]   nxm, nym;
  logic [DENW-1:0] dmag_nxt;

  always_comb begin
    nxm      = nx_r[NW-1] ? NW'(-nx_r) : NW'(nx_r);
    nym      = ny_r[NW-1] ? NW'(-ny_r) : NW'(ny_r);
    dmag_nxt = den3_r[DENW-1] ? DENW'(-den3_r) : DENW'(den3_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ax1_r    <= in_ax;
      ay1_r    <= in_ay;
      dx1_r    <= DIFW'(in_ax) - DIFW'(in_bx);
      dy1_r    <= DIFW'(in_ay) - DIFW'(in_by);
      dx2_r    <= DIFW'(in_ax) - DIFW'(in_cx);
      dy2_r    <= DIFW'(in_ay) - DIFW'(in_cy);
      ax2_r    <= SQW'(in_ax) * SQW'(in_ax);
      ay2_r    <= SQW'(in_ay) * SQW'(in_ay);
      bx2_r    <= SQW'(in_bx) * SQW'(in_bx);
      by2_r    <= SQW'(in_by) * SQW'(in_by);
      cx2_r    <= SQW'(in_cx) * SQW'(in_cx);
      cy2_r    <= SQW'(in_cy) * SQW'(in_cy);

      ax2c_r   <= ax1_r;
      ay2c_r   <= ay1_r;
      dx1b_r   <= dx1_r;
      dy1b_r   <= dy1_r;
      dx2b_r   <= dx2_r;
      dy2b_r   <= dy2_r;
      p1_r     <= PW'(dy2_r) * PW'(dx1_r);
      p2_r     <= PW'(dy1_r) * PW'(dx2_r);
      s1_r     <= SSW'(ax2_r) + SSW'(ay2_r) - SSW'(bx2_r) - SSW'(by2_r);
      s2_r     <= SSW'(ax2_r) + SSW'(ay2_r) - SSW'(cx2_r) - SSW'(cy2_r);

      ax3_r    <= ax2c_r;
      ay3_r    <= ay2c_r;
      den3_r   <= (DENW'(p1_r) - DENW'(p2_r)) <<< 1;
      m1_r     <= NPW'(s1_r) * NPW'(dy2b_r);
      m2_r     <= NPW'(s2_r) * NPW'(dy1b_r);
      m3_r     <= NPW'(s2_r) * NPW'(dx1b_r);
      m4_r     <= NPW'(s1_r) * NPW'(dx2b_r);

      ax4_r    <= ax3_r;
      ay4_r    <= ay3_r;
      nx_r     <= NW'(m1_r) - NW'(m2_r);
      ny_r     <= NW'(m3_r) - NW'(m4_r);
      dmag_r   <= dmag_nxt;
      dsgn4_r  <= den3_r[DENW-1];
      degen4_r <= dmag_nxt <= DENW'(limit_r);

      ax5_r    <= ax4_r;
      ay5_r    <= ay4_r;
      nnx5_r   <= (RW'(nxm) << 1) + RW'(dmag_r);
      nny5_r   <= (RW'(nym) << 1) + RW'(dmag_r);
      dd5_r    <= {dmag_r, 1'b0};
      negx5_r  <= nx_r[NW-1] ^ dsgn4_r;
      negy5_r  <= ny_r[NW-1] ^ dsgn4_r;
      degen5_r <= degen4_r;

      ax6_r    <= ax5_r;
      ay6_r    <= ay5_r;
      nnx6_r   <= nnx5_r;
      nny6_r   <= nny5_r;
      dd6_r    <= dd5_r;
      negx6_r  <= negx5_r;
      negy6_r  <= negy5_r;
      degen6_r <= degen5_r;
      ovx6_r   <= nnx5_r >= {dd5_r, {QB{1'b0}}};
      ovy6_r   <= nny5_r >= {dd5_r, {QB{1'b0}}};
    end
  end

  // division cell row
  logic          dv_v    [0:QB];
  logic [DW-1:0] dv_d    [0:QB];
  logic [RW-1:0] dv_rx   [0:QB];
  logic [RW-1:0] dv_ry   [0:QB];
  logic [QB-1:0] dv_qx   [0:QB];
  logic [QB-1:0] dv_qy   [0:QB];
  logic [DSW-1:0] dv_s   [0:QB];

  assign dv_v[0]  = v6_r;
  assign dv_d[0]  = dd6_r;
  assign dv_rx[0] = nnx6_r;
  assign dv_ry[0] = nny6_r;
  assign dv_qx[0] = '0;
  assign dv_qy[0] = '0;
  assign dv_s[0]  = {degen6_r, negx6_r, negy6_r, ovx6_r, ovy6_r, ax6_r, ay6_r};

  for (genvar k = 0; k < QB; k++) begin : g_div
    tcc_div_cell #(.DW(DW), .QB(QB), .STEP(QB - 1 - k), .SW(DSW)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl_in    ('{en: adv, valid: dv_v[k]}),
      .den_in    (dv_d[k]),
      .rem_x_in  (dv_rx[k]),
      .rem_y_in  (dv_ry[k]),
      .quo_x_in  (dv_qx[k]),
      .quo_y_in  (dv_qy[k]),
      .side_in   (dv_s[k]),
      .valid_out (dv_v[k+1]),
      .den_out   (dv_d[k+1]),
      .rem_x_out (dv_rx[k+1]),
      .rem_y_out (dv_ry[k+1]),
      .quo_x_out (dv_qx[k+1]),
      .quo_y_out (dv_qy[k+1]),
      .side_out  (dv_s[k+1])
    );
  end

  logic                dq_degen, dq_negx, dq_negy, dq_ovx, dq_ovy;
  logic signed [W-1:0] dq_ax, dq_ay;
  logic [QB-1:0]       qxm, qym;
  assign {dq_degen, dq_negx, dq_negy, dq_ovx, dq_ovy, dq_ax, dq_ay} = dv_s[QB];
  assign qxm = dq_ovx ? '1 : dv_qx[QB];
  assign qym = dq_ovy ? '1 : dv_qy[QB];

  // post stages: sign, clip, offsets, squares
  logic                  pa_v_r, pb_v_r, pc_v_r, pd_v_r, pe_v_r;
  logic signed [QSW-1:0] qx_r, qy_r;
  logic signed [W-1:0]   axa_r, aya_r;
  logic                  dga_r, dgb_r, dgc_r, dgd_r, dge_r;
  logic signed [W-1:0]   oxb_r, oyb_r, oxc_r, oyc_r, oxd_r, oyd_r, oxe_r, oye_r;
  logic                  stb_r, stc_r, std_r, ste_r;
  logic signed [EW-1:0]  ex_r, ey_r;
  logic [UW-1:0]         ux_r, uy_r;
  logic                  bgc_r, bgd_r, bge_r;
  logic [2*UW-1:0]       uxx_r, uyy_r;
  logic [VW-1:0]         vsum_r;

  logic                  clx_hi, clx_lo, cly_hi, cly_lo;
  logic [EW-1:0]         uxm, uym;

  always_comb begin
    clx_hi = qx_r > C_HI;
    clx_lo = qx_r < C_LO;
    cly_hi = qy_r > C_HI;
    cly_lo = qy_r < C_LO;
    uxm    = ex_r[EW-1] ? EW'(-ex_r) : EW'(ex_r);
    uym    = ey_r[EW-1] ? EW'(-ey_r) : EW'(ey_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pa_v_r <= 1'b0;
      pb_v_r <= 1'b0;
      pc_v_r <= 1'b0;
      pd_v_r <= 1'b0;
      pe_v_r <= 1'b0;
    end else if (adv) begin
      pa_v_r <= dv_v[QB];
      pb_v_r <= pa_v_r;
      pc_v_r <= pb_v_r;
      pd_v_r <= pc_v_r;
      pe_v_r <= pd_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      qx_r   <= dq_negx ? -QSW'({1'b0, qxm}) : QSW'({1'b0, qxm});
      qy_r   <= dq_negy ? -QSW'({1'b0, qym}) : QSW'({1'b0, qym});
      axa_r  <= dq_ax;
      aya_r  <= dq_ay;
      dga_r  <= dq_degen;

      oxb_r  <= clx_hi ? W'(C_HI) : (clx_lo ? W'(C_LO) : W'(qx_r));
      oyb_r  <= cly_hi ? W'(C_HI) : (cly_lo ? W'(C_LO) : W'(qy_r));
      stb_r  <= clx_hi | clx_lo | cly_hi | cly_lo;
      ex_r   <= EW'(qx_r) - EW'(axa_r);
      ey_r   <= EW'(qy_r) - EW'(aya_r);
      dgb_r  <= dga_r;

      ux_r   <= UW'(uxm);
      uy_r   <= UW'(uym);
      bgc_r  <= (uxm >= LIM) | (uym >= LIM);
      oxc_r  <= oxb_r;
      oyc_r  <= oyb_r;
      stc_r  <= stb_r;
      dgc_r  <= dgb_r;

      uxx_r  <= (2*UW)'(ux_r) * (2*UW)'(ux_r);
      uyy_r  <= (2*UW)'(uy_r) * (2*UW)'(uy_r);
      bgd_r  <= bgc_r;
      oxd_r  <= oxc_r;
      oyd_r  <= oyc_r;
      std_r  <= stc_r;
      dgd_r  <= dgc_r;

      vsum_r <= VW'(uxx_r) + VW'(uyy_r);
      bge_r  <= bgd_r;
      oxe_r  <= oxd_r;
      oye_r  <= oyd_r;
      ste_r  <= std_r;
      dge_r  <= dgd_r;
    end
  end

  // square root cell row
  logic           sq_v [0:SK];
  logic [VW-1:0]  sq_x [0:SK];
  logic [VW-1:0]  sq_r [0:SK];
  logic [SSD-1:0] sq_s [0:SK];

  assign sq_v[0] = pe_v_r;
  assign sq_x[0] = vsum_r;
  assign sq_r[0] = '0;
  assign sq_s[0] = {dge_r, bge_r, ste_r, oxe_r, oye_r};

  for (genvar k = 0; k < SK; k++) begin : g_sqrt
    tcc_sqrt_cell #(.VW(VW), .STEP(SK - 1 - k), .SW(SSD)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl_in    ('{en: adv, valid: sq_v[k]}),
      .x_in      (sq_x[k]),
      .r_in      (sq_r[k]),
      .side_in   (sq_s[k]),
      .valid_out (sq_v[k+1]),
      .x_out     (sq_x[k+1]),
      .r_out     (sq_r[k+1]),
      .side_out  (sq_s[k+1])
    );
  end

  // rounding and output register
  logic                fq_degen, fq_big, fq_sat;
  logic signed [W-1:0] fq_ox, fq_oy;
  logic [RTW-1:0]      root_rnd;
  logic                rclip;
  logic [W-1:0]        rad;

  assign {fq_degen, fq_big, fq_sat, fq_ox, fq_oy} = sq_s[SK];

  always_comb begin
    root_rnd = RTW'(sq_r[SK]) + RTW'(sq_x[SK] > sq_r[SK]);
    rclip    = fq_big | (root_rnd > RMAX);
    rad      = rclip ? W'(RMAX) : W'(root_rnd);
  end

  logic            out_valid_r;
  logic [OUTW-1:0] out_data_r;
  logic [1:0]      out_user_r;

  assign out_load  = !out_valid_r || out_tready;
  assign adv       = out_load || !sq_v[SK];
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= sq_v[SK];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (fq_degen) begin
        out_data_r <= '0;
        out_user_r <= 2'b01;
      end else begin
        out_data_r <= OUTW'({rad, fq_oy, fq_ox});
        out_user_r <= {fq_sat | rclip, 1'b0};
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata == '0 && !out_tuser[1]))
    else $error("degenerate result carries nonzero fields");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready && sq_v[SK]))
    else $error("input held off without a blocked full pipe");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(sq_v[SK]))
    else $error("result appeared without a finished item");

endmodule

`default_nettype wire
